// ----- rtl/sdspi_pkg.sv -----
// Package for the SD SPI-mode command engine: word types, transaction context,
// phase codes, protocol constants and the command frame byte selector.
// Depends on nothing; imported by every module of the block.
package sdspi_pkg;

  // Phase codes of the transaction sequencer
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_READY = 3'd1;
  localparam logic [2:0] PH_SEND  = 3'd2;
  localparam logic [2:0] PH_POST  = 3'd3;
  localparam logic [2:0] PH_STUFF = 3'd4;
  localparam logic [2:0] PH_R1    = 3'd5;
  localparam logic [2:0] PH_TRAIL = 3'd6;
  localparam logic [2:0] PH_FINAL = 3'd7;

  // Input word codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_RX    = 1'b1;

  // Protocol constants
  localparam logic [7:0] CMD_START_BITS = 8'h40;
  localparam logic [7:0] CRC_CMD0       = 8'h95;
  localparam logic [7:0] CRC_CMD8       = 8'h87;
  localparam logic [7:0] CRC_DUMMY      = 8'h01;
  localparam logic [7:0] IDLE_BYTE      = 8'hFF;
  localparam logic [5:0] IDX_GO_IDLE    = 6'd0;
  localparam logic [5:0] IDX_SEND_COND  = 6'd8;
  localparam logic [5:0] IDX_STOP_TRAN  = 6'd12;
  localparam logic [7:0] FRAME_LAST     = 8'd5;
  localparam logic [7:0] TRAILER_BYTES  = 8'd4;
  localparam logic [7:0] POLL_RESET     = 8'd255;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic        want_trailer;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_request;
    logic        chip_select;
    logic        done_res;
    logic        status;
    logic [7:0]  r1_byte;
    logic [31:0] trailer;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [7:0]  poll_count;
    logic [5:0]  held_index;
    logic [31:0] held_argument;
    logic        held_want_trailer;
    logic [7:0]  held_r1;
    logic [31:0] trailer_shift;
    logic        select_level;
  } ctx_t;

  // Byte k of the six-byte command frame
  function automatic logic [7:0] cmd_byte(input logic [5:0] idx, input logic [31:0] arg,
                                          input logic [7:0] k);
    logic [7:0] b;
    case (k)
      8'd0: b = CMD_START_BITS | {2'b00, idx};
      8'd1: b = arg[31:24];
      8'd2: b = arg[23:16];
      8'd3: b = arg[15:8];
      8'd4: b = arg[7:0];
      default: begin
        if (idx == IDX_GO_IDLE) b = CRC_CMD0;
        else if (idx == IDX_SEND_COND) b = CRC_CMD8;
        else b = CRC_DUMMY;
      end
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/sdspi_step.sv -----
// Next-context and result logic for one word of the SD SPI command engine.
// Purely combinational; depends on sdspi_pkg.
module sdspi_step import sdspi_pkg::*; (
  input  in_item_t   item,
  input  ctx_t       ctx,
  input  logic [7:0] poll_limit,
  output ctx_t       ctx_next,
  output out_item_t  res
);

  logic [7:0] pc_inc;

  assign pc_inc = ctx.poll_count + 8'd1;

  always_comb begin
    ctx_next        = ctx;
    res.tx_byte     = IDLE_BYTE;
    res.tx_request  = 1'b0;
    res.done_res    = 1'b0;
    res.status      = 1'b0;
    res.r1_byte     = 8'd0;
    res.trailer     = 32'd0;

    if (item.cmd == OP_START) begin
      ctx_next.held_index        = item.cmd_index;
      ctx_next.held_argument     = item.argument;
      ctx_next.held_want_trailer = item.want_trailer;
      ctx_next.held_r1           = 8'd0;
      ctx_next.trailer_shift     = 32'd0;
      ctx_next.select_level      = 1'b1;
      res.tx_request             = 1'b1;
      if (item.cmd_index != IDX_GO_IDLE) begin
        ctx_next.phase      = PH_READY;
        ctx_next.poll_count = 8'd0;
      end else begin
        ctx_next.phase      = PH_SEND;
        ctx_next.poll_count = 8'd1;
        res.tx_byte         = cmd_byte(item.cmd_index, item.argument, 8'd0);
      end
    end else begin
      case (ctx.phase)
        PH_READY: begin
          if (item.rx_byte == IDLE_BYTE) begin
            ctx_next.phase      = PH_SEND;
            ctx_next.poll_count = 8'd1;
            res.tx_request      = 1'b1;
            res.tx_byte         = cmd_byte(ctx.held_index, ctx.held_argument, 8'd0);
          end else if (ctx.poll_count >= poll_limit) begin
            // card never ready: give up, select stays asserted
            ctx_next.phase = PH_IDLE;
            res.done_res   = 1'b1;
            res.status     = 1'b1;
            res.r1_byte    = IDLE_BYTE;
          end else begin
            ctx_next.poll_count = pc_inc;
            res.tx_request      = 1'b1;
          end
        end
        PH_SEND: begin
          res.tx_request = 1'b1;
          res.tx_byte    = cmd_byte(ctx.held_index, ctx.held_argument, ctx.poll_count);
          if (ctx.poll_count >= FRAME_LAST) ctx_next.phase = PH_POST;
          else ctx_next.poll_count = pc_inc;
        end
        PH_POST, PH_STUFF: begin
          res.tx_request = 1'b1;
          if (ctx.phase == PH_POST && ctx.held_index == IDX_STOP_TRAN) begin
            ctx_next.phase = PH_STUFF;
          end else if (poll_limit != 8'd0) begin
            ctx_next.phase      = PH_R1;
            ctx_next.poll_count = 8'd0;
          end else begin
            ctx_next.held_r1 = 8'd0;
            if (ctx.held_want_trailer) begin
              ctx_next.phase      = PH_TRAIL;
              ctx_next.poll_count = 8'd0;
            end else begin
              ctx_next.phase        = PH_FINAL;
              ctx_next.select_level = 1'b0;
            end
          end
        end
        PH_R1: begin
          res.tx_request      = 1'b1;
          ctx_next.held_r1    = item.rx_byte;
          ctx_next.poll_count = pc_inc;
          if (!item.rx_byte[7] || pc_inc >= poll_limit) begin
            if (ctx.held_want_trailer) begin
              ctx_next.phase      = PH_TRAIL;
              ctx_next.poll_count = 8'd0;
            end else begin
              ctx_next.phase        = PH_FINAL;
              ctx_next.select_level = 1'b0;
            end
          end
        end
        PH_TRAIL: begin
          res.tx_request         = 1'b1;
          ctx_next.trailer_shift = {ctx.trailer_shift[23:0], item.rx_byte};
          ctx_next.poll_count    = pc_inc;
          if (pc_inc >= TRAILER_BYTES) begin
            ctx_next.phase        = PH_FINAL;
            ctx_next.select_level = 1'b0;
          end
        end
        PH_FINAL: begin
          ctx_next.phase = PH_IDLE;
          res.done_res   = 1'b1;
          res.r1_byte    = ctx.held_r1;
          res.trailer    = ctx.trailer_shift;
        end
        default: begin
          // idle: drop received bytes
        end
      endcase
    end

    res.chip_select = ctx_next.select_level;
  end

endmodule

// ----- rtl/sd_spi_command_engine.sv -----
// SD card SPI-mode command engine, top level: input register, context and
// result register around sdspi_step. Depends on sdspi_pkg and sdspi_step.
//
// Host-side sequencer for one SD SPI command transaction. Send a start word
// (cmd 0) with the command index, argument and trailer request; the engine
// asserts select and answers with the byte to shift out next. Feed every
// following byte received from the card back as a cmd 1 word. Each word in
// produces exactly one result word: tx_byte/tx_request tell the SPI master
// whether to run another exchange, chip_select gives the select level, and
// done_res marks the word that finishes the transaction with status, R1 and
// the optional four-byte trailer. A card that never reports ready finishes
// with status 1, R1 0xFF and select still asserted. A start word while a
// transaction runs abandons it. Throughput is one word per clock while the
// result register is read. A taken word sits in the input register, passes
// through the whole per-word step and is registered into the result register
// when it advances. The result register takes a new word only when it is
// empty or being read in the same cycle; the input register keeps taking
// words until it too holds one, so the input side only stalls when both
// stages are full. poll_limit (reset 255) may be written on the
// cfg channel only while no transaction is active and no word is in flight.
module sd_spi_command_engine import sdspi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data
);

  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_adv;
  ctx_t      ctx;
  ctx_t      ctx_next;
  out_item_t res;
  logic [7:0] poll_limit;

  // Advance the held word whenever the result register is free or draining
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= POLL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      poll_limit <= cfg_data;
    end
  end

  sdspi_step u_step (
    .item       (s1_item),
    .ctx        (ctx),
    .poll_limit (poll_limit),
    .ctx_next   (ctx_next),
    .res        (res)
  );

  // Transaction context: commit only when the word moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx <= '0;
    end else if (s1_adv) begin
      ctx <= ctx_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item <= res;
    end
  end

`ifndef ASSERT_OFF
  // A finished transaction never asks for another exchange
  a_done_no_req: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.done_res |-> !out_item.tx_request)
    else $error("done word requests an exchange");

  // Failure status only appears on a done word
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status |-> out_item.done_res)
    else $error("status set without done");

  // Select is released only in the closing clock byte or when idle
  a_select_phase: assert property (@(posedge clk) disable iff (rst)
    !ctx.select_level |-> (ctx.phase == PH_IDLE || ctx.phase == PH_FINAL))
    else $error("select released mid transaction");

  // The context moves only when a word passes to the result register
  a_ctx_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> $stable(ctx))
    else $error("context changed without a word");
`endif

endmodule

// ----- tb/sv/sd_spi_command_engine_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sd_spi_command_engine: drives command and card-byte words,
// predicts each result word from a behavioural copy of the engine and checks it field by field.
// Depends on sdspi_pkg and the RTL of the engine only.
module sd_spi_command_engine_tb;
  import sdspi_pkg::*;

  // Generous bound on the whole run; the slowest legal run is far shorter.
  localparam int CYCLE_LIMIT = 200000;
  // Length of the receiver hold-off used to fill the engine and stall its input.
  localparam int HOLD_OFF_CYCLES = 300;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = '0;

  // Idle percentages of the two sides, changed between test phases.
  int send_idle_pct = 15;
  int recv_idle_pct = 75;
  // Hold-off requests: the stimulus bumps stall_req, the receiver notices the change.
  int stall_req = 0;
  int stall_seen = 0;
  int hold_left = 0;

  int mismatches = 0;
  int cycle_count = 0;

  // Result words predicted for accepted input words, oldest first.
  out_item_t pending_results[$];
  out_item_t due_word;

  // Behavioural copy of the engine state, at its reset values.
  logic [2:0]  eng_phase = PH_IDLE;
  logic [7:0]  eng_count = '0;
  logic [5:0]  eng_index = '0;
  logic [31:0] eng_arg = '0;
  logic        eng_trailer_wanted = 1'b0;
  logic [7:0]  eng_r1 = '0;
  logic [31:0] eng_trailer = '0;
  logic        eng_select = 1'b0;
  logic [7:0]  poll_limit_q = POLL_RESET;

  sd_spi_command_engine DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Byte k of the six-byte command frame: start bits and index, argument MSB first, CRC.
  function automatic logic [7:0] frame_byte(input logic [7:0] k);
    case (k)
      8'd0: return CMD_START_BITS | {2'b00, eng_index};
      8'd1: return eng_arg[31:24];
      8'd2: return eng_arg[23:16];
      8'd3: return eng_arg[15:8];
      8'd4: return eng_arg[7:0];
      default: begin
        if (eng_index == IDX_GO_IDLE) return CRC_CMD0;
        if (eng_index == IDX_SEND_COND) return CRC_CMD8;
        return CRC_DUMMY;
      end
    endcase
  endfunction

  // Advance the engine copy by one accepted word and return the result word it yields.
  function automatic out_item_t advance_engine(input in_item_t w);
    out_item_t o;
    logic      open_resp;
    logic      close_r1;
    logic      release_cs;
    o = '0;
    o.tx_byte = IDLE_BYTE;
    open_resp = 1'b0;
    close_r1 = 1'b0;
    release_cs = 1'b0;
    if (w.cmd == OP_START) begin
      // Latch the command and assert select; a running transaction is simply dropped.
      eng_index = w.cmd_index;
      eng_arg = w.argument;
      eng_trailer_wanted = w.want_trailer;
      eng_r1 = '0;
      eng_trailer = '0;
      eng_count = '0;
      eng_select = 1'b1;
      o.tx_request = 1'b1;
      if (eng_index != IDX_GO_IDLE) begin
        eng_phase = PH_READY;
      end else begin
        // CMD0 goes straight to the frame: the card is not expected to report ready.
        eng_phase = PH_SEND;
        o.tx_byte = frame_byte(8'd0);
        eng_count = 8'd1;
      end
    end else begin
      case (eng_phase)
        PH_READY: begin
          if (w.rx_byte == IDLE_BYTE) begin
            eng_phase = PH_SEND;
            o.tx_byte = frame_byte(8'd0);
            o.tx_request = 1'b1;
            eng_count = 8'd1;
          end else if (eng_count >= poll_limit_q) begin
            // Card never became ready: report busy, leave select asserted.
            eng_phase = PH_IDLE;
            o.done_res = 1'b1;
            o.status = 1'b1;
            o.r1_byte = IDLE_BYTE;
          end else begin
            eng_count = eng_count + 8'd1;
            o.tx_request = 1'b1;
          end
        end
        PH_SEND: begin
          // Bytes received while the frame goes out carry nothing.
          o.tx_byte = frame_byte(eng_count);
          o.tx_request = 1'b1;
          if (eng_count >= FRAME_LAST) eng_phase = PH_POST;
          else eng_count = eng_count + 8'd1;
        end
        PH_POST: begin
          if (eng_index == IDX_STOP_TRAN) begin
            // Stop transmission: skip the stuff byte first.
            eng_phase = PH_STUFF;
            o.tx_request = 1'b1;
          end else begin
            open_resp = 1'b1;
          end
        end
        PH_STUFF: open_resp = 1'b1;
        PH_R1: begin
          eng_r1 = w.rx_byte;
          eng_count = eng_count + 8'd1;
          if (!w.rx_byte[7] || eng_count >= poll_limit_q) close_r1 = 1'b1;
          else o.tx_request = 1'b1;
        end
        PH_TRAIL: begin
          eng_trailer = {eng_trailer[23:0], w.rx_byte};
          eng_count = eng_count + 8'd1;
          if (eng_count >= TRAILER_BYTES) release_cs = 1'b1;
          else o.tx_request = 1'b1;
        end
        PH_FINAL: begin
          eng_phase = PH_IDLE;
          o.done_res = 1'b1;
          o.r1_byte = eng_r1;
          o.trailer = eng_trailer;
        end
        default: ;
      endcase
    end
    if (open_resp) begin
      if (poll_limit_q != 8'd0) begin
        eng_phase = PH_R1;
        eng_count = '0;
        o.tx_request = 1'b1;
      end else begin
        // Zero poll limit: no R1 polls at all, R1 taken as zero.
        eng_r1 = '0;
        close_r1 = 1'b1;
      end
    end
    if (close_r1) begin
      if (eng_trailer_wanted) begin
        eng_phase = PH_TRAIL;
        eng_count = '0;
        o.tx_request = 1'b1;
      end else begin
        release_cs = 1'b1;
      end
    end
    if (release_cs) begin
      // Drop select and clock one more byte; completion comes with that byte.
      eng_select = 1'b0;
      eng_phase = PH_FINAL;
      o.tx_request = 1'b1;
    end
    o.chip_select = eng_select;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // Receiver: check each delivered word against the oldest prediction, then pick
  // the next ready level, holding off for a long stretch when asked.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing expected (tx_byte)", 32'(out_item.tx_byte), '0);
      end else begin
        due_word = pending_results.pop_front();
        if (out_item.tx_byte !== due_word.tx_byte)
          report_mismatch("tx_byte", 32'(out_item.tx_byte), 32'(due_word.tx_byte));
        if (out_item.tx_request !== due_word.tx_request)
          report_mismatch("tx_request", 32'(out_item.tx_request), 32'(due_word.tx_request));
        if (out_item.chip_select !== due_word.chip_select)
          report_mismatch("chip_select", 32'(out_item.chip_select),
                          32'(due_word.chip_select));
        if (out_item.done_res !== due_word.done_res)
          report_mismatch("done_res", 32'(out_item.done_res), 32'(due_word.done_res));
        if (out_item.status !== due_word.status)
          report_mismatch("status", 32'(out_item.status), 32'(due_word.status));
        if (out_item.r1_byte !== due_word.r1_byte)
          report_mismatch("r1_byte", 32'(out_item.r1_byte), 32'(due_word.r1_byte));
        if (out_item.trailer !== due_word.trailer)
          report_mismatch("trailer", out_item.trailer, due_word.trailer);
      end
    end
    if (stall_req != stall_seen) begin
      stall_seen = stall_req;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one word after a random gap, hold it until taken, then record its prediction.
  task automatic send_word(input in_item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(advance_engine(w));
  endtask

  // Start a command; the unused received-byte field carries noise.
  task automatic start_cmd(input logic [5:0] idx, input logic [31:0] arg, input logic tr);
    in_item_t w;
    w.cmd = OP_START;
    w.cmd_index = idx;
    w.argument = arg;
    w.want_trailer = tr;
    w.rx_byte = 8'($urandom_range(255));
    send_word(w);
  endtask

  // Return a byte received from the card; the command fields carry noise.
  task automatic feed_byte(input logic [7:0] b);
    in_item_t w;
    w.cmd = OP_RX;
    w.cmd_index = 6'($urandom_range(63));
    w.argument = $urandom();
    w.want_trailer = 1'($urandom_range(1));
    w.rx_byte = b;
    send_word(w);
  endtask

  // Stop offering and wait for every predicted word to come out.
  task automatic idle_until_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Bring the engine to rest, then write poll_limit over the cfg channel.
  task automatic write_poll_limit(input logic [7:0] value);
    // Answer as a willing card so any open transaction ends within a few words.
    while (eng_phase != PH_IDLE) feed_byte(eng_phase == PH_READY ? IDLE_BYTE : 8'h00);
    idle_until_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    poll_limit_q = value;
  endtask

  // Favour the indexes with special handling, otherwise any index.
  function automatic logic [5:0] random_index();
    case ($urandom_range(3))
      0: return IDX_GO_IDLE;
      1: return IDX_SEND_COND;
      2: return IDX_STOP_TRAN;
      default: return 6'($urandom_range(63));
    endcase
  endfunction

  // Act as a card: mostly well-formed transactions with random content, some
  // abandoned by a fresh start, some stray bytes while idle.
  task automatic card_traffic(input int n_words);
    int sent;
    int pick;
    logic [7:0] b;
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(99);
      if (eng_phase == PH_IDLE) begin
        if (pick < 5) begin
          // Stray byte while idle: ignored, not counted.
          feed_byte(8'($urandom_range(255)));
        end else begin
          start_cmd(random_index(), $urandom(), 1'($urandom_range(1)));
          sent++;
        end
      end else if (pick < 2) begin
        start_cmd(random_index(), $urandom(), 1'($urandom_range(1)));
        sent++;
      end else begin
        case (eng_phase)
          PH_READY: b = (pick < 50) ? IDLE_BYTE : 8'($urandom_range(254));
          PH_R1:    b = (pick < 55) ? {1'b0, 7'($urandom_range(127))}
                                    : {1'b1, 7'($urandom_range(127))};
          default:  b = 8'($urandom_range(255));
        endcase
        feed_byte(b);
        sent++;
      end
    end
  endtask

  // A byte with no transaction open must be ignored.
  task automatic test_idle_byte();
    feed_byte(8'h5A);
  endtask

  // Card stays busy past the smallest non-zero limit: busy report, select kept.
  task automatic test_card_never_ready();
    write_poll_limit(8'd1);
    start_cmd(6'd17, 32'h0000_0000, 1'b1);
    feed_byte(8'h00);
    feed_byte(8'hFE);
  endtask

  // Zero limit: one ready read only, and no R1 polling (R1 reads as zero).
  task automatic test_zero_poll_limit();
    write_poll_limit(8'd0);
    start_cmd(6'd1, 32'h1234_5678, 1'b0);
    feed_byte(8'h7F);
    start_cmd(IDX_GO_IDLE, 32'hFFFF_FFFF, 1'b0);
    // Five frame bytes, the post-frame byte and the closing byte.
    repeat (7) feed_byte(8'($urandom_range(255)));
  endtask

  // Stop transmission with a trailer at the largest limit: stuff byte, one busy R1
  // poll, then R1 and four trailer bytes.
  task automatic test_stop_transmission();
    logic [7:0] card_bytes[] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h33,
                                 8'hC4, 8'hFF, 8'h00, 8'hDE, 8'hAD, 8'hBE, 8'hEF,
                                 8'h81};
    write_poll_limit(8'd255);
    start_cmd(IDX_STOP_TRAN, 32'hA5C3_0F96, 1'b1);
    foreach (card_bytes[i]) feed_byte(card_bytes[i]);
  endtask

  // A start in the middle of a transaction abandons it.
  task automatic test_start_while_busy();
    start_cmd(IDX_SEND_COND, 32'h0000_01AA, 1'b1);
    feed_byte(IDLE_BYTE);
    feed_byte(8'h48);
    start_cmd(6'd63, 32'h8000_0001, 1'b0);
    feed_byte(IDLE_BYTE);
  endtask

  // One phase of random traffic at a given idling mix and poll limit.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input logic [7:0] limit, input int n_words);
    write_poll_limit(limit);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    card_traffic(n_words);
  endtask

  // Hold the receiver off while words keep coming so the engine fills and stalls,
  // then pause the sender until everything has drained.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_req <= stall_req + 1;
    card_traffic(60);
    idle_until_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_byte();
    test_card_never_ready();
    test_zero_poll_limit();
    test_stop_transmission();
    test_start_while_busy();

    test_random_traffic(15, 75, 8'd255, 530);
    test_random_traffic(75, 15, 8'd3, 530);
    test_random_traffic(0, 0, 8'($urandom_range(1, 255)), 540);
    test_backpressure();

    // Let any stray word show up before the verdict.
    idle_until_drained();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("words never delivered", 32'(pending_results.size()), '0);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
